// File: sv/sfvm_pkg.sv
package sfvm_pkg;

    typedef enum logic [3:0] {
        K_PUSH       = 4'd0,
        K_POP        = 4'd1,
        K_TO_STACK   = 4'd2,
        K_FROM_STACK = 4'd3,
        K_TO_RETSLOT = 4'd4,
        K_MOVE       = 4'd5,
        K_LOAD       = 4'd6,
        K_EMIT       = 4'd7,
        K_RETURN     = 4'd8,
        K_EXIT       = 4'd9,
        K_CALL       = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EXIT   = 3'd1,
        ST_SOVF   = 3'd2,
        ST_SUNF   = 3'd3,
        ST_BADREG = 3'd4,
        ST_FOVF   = 3'd5,
        ST_HALT   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        M_CLEAR = 2'b01,
        M_RUN   = 2'b10
    } t_mode;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [63:0] in_value;
        logic [15:0] callee_entry;
        logic [3:0]  callee_args;
    } t_in_item;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        out_valid;
        logic [63:0] out_value;
        logic [2:0]  status;
        logic [63:0] exit_value;
    } t_out_item;

endpackage

// File: sv/sfvm_ram.sv
module sfvm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read with write-through on an address match
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/stack_frame_vm_execute_unit_core.sv
// Execute unit of a small register-and-stack virtual machine: one decoded instruction
// per input transaction, one result transaction per instruction. Instructions are taken
// one per clock unless output back-pressure stalls them; an accepted instruction first
// reads the register file, data stack and frame store (synchronous memories with a
// registered read and write-through on an address match), then executes, writes back and
// registers its result. The current frame's base and top sit in registers; the frame
// store holds the saved caller frames. After reset the block clears the register file and
// data stack, one entry per cycle, and accepts no instruction meanwhile; a start address
// write is taken at any time while idle and loads the program counter only until the
// first instruction. Any error or a successful exit halts the block until reset, and
// every later instruction reports the halted status.
module stack_frame_vm_execute_unit_core
    import sfvm_pkg::*;
#(
    parameter int REG_COUNT   = 16,
    parameter int STACK_DEPTH = 16,
    parameter int FRAME_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    localparam int RW    = $clog2(REG_COUNT);
    localparam int SW    = $clog2(STACK_DEPTH);
    localparam int FW    = $clog2(FRAME_DEPTH);
    localparam int CLR_N = (REG_COUNT > STACK_DEPTH) ? REG_COUNT : STACK_DEPTH;
    localparam int CW    = $clog2(CLR_N);
    localparam int CMPW  = ((SW > 5) ? SW : 5) + 1;
    localparam int FRW   = 2 * SW + 16;

    t_mode           r_mode;
    logic [CW-1:0]   r_clr_cnt;
    logic            r_s1_valid;
    t_in_item        r_s1;
    logic            r_out_valid;
    t_out_item       r_out;
    logic [15:0]     r_pc;
    logic [FW-1:0]   r_fi;
    logic [SW-1:0]   r_base;
    logic [SW-1:0]   r_top;
    logic            r_halted;
    logic            r_fresh;

    logic [15:0]     n_pc;
    logic [FW-1:0]   n_fi;
    logic [SW-1:0]   n_base;
    logic [SW-1:0]   n_top;
    logic            n_halted;

    logic            w_adv;
    logic            w_in_acc;
    logic            w_clearing;

    logic [63:0]     w_rf_rd;
    logic [63:0]     w_stk_rd;
    logic [FRW-1:0]  w_frm_rd;

    logic            rf_we;
    logic [RW-1:0]   rf_waddr;
    logic [63:0]     rf_wdata;
    logic            stk_we;
    logic [SW-1:0]   stk_waddr;
    logic [63:0]     stk_wdata;
    logic [FW-1:0]   frm_raddr;
    logic [FRW-1:0]  frm_wdata;

    t_status         ex_status;
    logic [15:0]     ex_npc;
    logic            ex_ovalid;
    logic [63:0]     ex_oval;
    logic [63:0]     ex_xval;
    logic [SW-1:0]   ex_base;
    logic [SW-1:0]   ex_top;
    logic [FW-1:0]   ex_fi;
    logic            ex_rf_we;
    logic [RW-1:0]   ex_rf_waddr;
    logic [63:0]     ex_rf_wdata;
    logic            ex_stk_we;
    logic [SW-1:0]   ex_stk_waddr;
    logic            ex_frm_we;
    t_out_item       ex_res;

    logic [15:0]     w_pc_inc;
    logic [SW-1:0]   w_top_m1;
    logic            w_nonempty;
    logic            w_push_ok;
    logic            w_ret_ok;
    logic            w_uses_ra;
    logic            w_ra_bad;
    logic            w_rb_bad;
    logic [4:0]      w_shared;
    logic            w_args_short;

    assign w_clearing = (r_mode == M_CLEAR);
    assign w_adv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !w_clearing && (!r_s1_valid || w_adv);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // execute stage
    assign w_pc_inc     = r_pc + 16'd1;
    assign w_top_m1     = r_top - SW'(1);
    assign w_nonempty   = (r_base < r_top);
    assign w_push_ok    = ((CMPW'(r_top) + CMPW'(1)) < CMPW'(STACK_DEPTH));
    assign w_ret_ok     = ((CMPW'(r_base) + CMPW'(1)) < CMPW'(STACK_DEPTH));
    assign w_shared     = {1'b0, r_s1.callee_args} + 5'd1;
    assign w_args_short = (CMPW'(r_top) < (CMPW'(r_base) + CMPW'(w_shared)));
    assign w_uses_ra    = (r_s1.kind >= K_TO_STACK) && (r_s1.kind <= K_EMIT);
    assign w_ra_bad     = ({1'b0, r_s1.reg_a} >= 9'(REG_COUNT));
    assign w_rb_bad     = ({1'b0, r_s1.reg_b} >= 9'(REG_COUNT));

    always_comb begin
        ex_status    = ST_OK;
        ex_npc       = w_pc_inc;
        ex_ovalid    = 1'b0;
        ex_oval      = '0;
        ex_xval      = '0;
        ex_base      = r_base;
        ex_top       = r_top;
        ex_fi        = r_fi;
        ex_rf_we     = 1'b0;
        ex_rf_waddr  = r_s1.reg_a[RW-1:0];
        ex_rf_wdata  = r_s1.in_value;
        ex_stk_we    = 1'b0;
        ex_stk_waddr = w_top_m1;
        ex_frm_we    = 1'b0;
        if (r_halted) begin
            ex_status = ST_HALT;
        end else if (w_uses_ra && w_ra_bad) begin
            ex_status = ST_BADREG;
        end else if ((r_s1.kind == K_MOVE) && w_rb_bad) begin
            ex_status = ST_BADREG;
        end else begin
            case (r_s1.kind)
                K_PUSH: begin
                    if (w_push_ok) begin
                        ex_top = r_top + SW'(1);
                    end else begin
                        ex_status = ST_SOVF;
                    end
                end
                K_POP: begin
                    if (w_nonempty) begin
                        ex_top = w_top_m1;
                    end else begin
                        ex_status = ST_SUNF;
                    end
                end
                K_TO_STACK: begin
                    if (w_nonempty) begin
                        ex_stk_we = 1'b1;
                    end else begin
                        ex_status = ST_SUNF;
                    end
                end
                K_FROM_STACK: begin
                    if (w_nonempty) begin
                        ex_rf_we    = 1'b1;
                        ex_rf_wdata = w_stk_rd;
                    end else begin
                        ex_status = ST_SUNF;
                    end
                end
                K_TO_RETSLOT: begin
                    ex_stk_we    = 1'b1;
                    ex_stk_waddr = r_base;
                end
                K_MOVE: begin
                    ex_rf_we    = 1'b1;
                    ex_rf_waddr = r_s1.reg_b[RW-1:0];
                    ex_rf_wdata = w_rf_rd;
                end
                K_LOAD: begin
                    ex_rf_we = 1'b1;
                end
                K_EMIT: begin
                    ex_ovalid = 1'b1;
                    ex_oval   = w_rf_rd;
                end
                K_RETURN: begin
                    if (r_fi == '0) begin
                        ex_status = ST_HALT;
                    end else if (!w_ret_ok) begin
                        ex_status = ST_SOVF;
                    end else begin
                        ex_base = w_frm_rd[FRW-1 -: SW];
                        ex_top  = w_frm_rd[SW+15 -: SW];
                        ex_fi   = r_fi - FW'(1);
                        ex_npc  = w_frm_rd[15:0];
                    end
                end
                K_EXIT: begin
                    if ((r_fi == '0) && (r_top == SW'(1))) begin
                        ex_status = ST_EXIT;
                        ex_xval   = w_stk_rd;
                    end else begin
                        ex_status = ST_HALT;
                    end
                end
                K_CALL: begin
                    if (r_fi == FW'(FRAME_DEPTH - 1)) begin
                        ex_status = ST_FOVF;
                    end else if (w_args_short) begin
                        ex_status = ST_SUNF;
                    end else begin
                        ex_frm_we = 1'b1;
                        ex_base   = SW'(CMPW'(r_top) - CMPW'(w_shared));
                        ex_fi     = r_fi + FW'(1);
                        ex_npc    = r_s1.callee_entry;
                    end
                end
                default: begin
                end
            endcase
        end
        if (ex_status != ST_OK) begin
            ex_npc = r_pc;
        end
        ex_res.next_pc    = ex_npc;
        ex_res.out_valid  = ex_ovalid;
        ex_res.out_value  = ex_oval;
        ex_res.status     = ex_status;
        ex_res.exit_value = ex_xval;
    end

    assign n_pc     = w_adv ? ex_npc : r_pc;
    assign n_fi     = w_adv ? ex_fi : r_fi;
    assign n_base   = w_adv ? ex_base : r_base;
    assign n_top    = w_adv ? ex_top : r_top;
    assign n_halted = r_halted || (w_adv && (ex_status != ST_OK));

    // memory write ports, shared with the clearing sweep
    always_comb begin
        if (w_clearing) begin
            rf_we     = ({1'b0, r_clr_cnt} < (CW + 1)'(REG_COUNT));
            rf_waddr  = r_clr_cnt[RW-1:0];
            rf_wdata  = '0;
            stk_we    = ({1'b0, r_clr_cnt} < (CW + 1)'(STACK_DEPTH));
            stk_waddr = r_clr_cnt[SW-1:0];
            stk_wdata = '0;
        end else begin
            rf_we     = w_adv && ex_rf_we;
            rf_waddr  = ex_rf_waddr;
            rf_wdata  = ex_rf_wdata;
            stk_we    = w_adv && ex_stk_we;
            stk_waddr = ex_stk_waddr;
            stk_wdata = w_rf_rd;
        end
    end

    assign frm_wdata = {r_base, r_top, w_pc_inc};
    assign frm_raddr = (n_fi == '0) ? '0 : (n_fi - FW'(1));

    sfvm_ram #(
        .DEPTH (REG_COUNT),
        .WIDTH (64)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (w_in_acc),
        .i_raddr (i_in.reg_a[RW-1:0]),
        .o_rdata (w_rf_rd)
    );

    sfvm_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (64)
    ) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (w_in_acc),
        .i_raddr (n_top - SW'(1)),
        .o_rdata (w_stk_rd)
    );

    // caller frame of the current frame, refetched every cycle
    sfvm_ram #(
        .DEPTH (FRAME_DEPTH),
        .WIDTH (FRW)
    ) u_frm (
        .i_clk   (i_clk),
        .i_we    (w_adv && ex_frm_we),
        .i_waddr (r_fi),
        .i_wdata (frm_wdata),
        .i_re    (1'b1),
        .i_raddr (frm_raddr),
        .o_rdata (w_frm_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_CLEAR;
            r_clr_cnt   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_fi        <= '0;
            r_base      <= '0;
            r_top       <= '0;
            r_halted    <= 1'b0;
            r_fresh     <= 1'b1;
        end else begin
            case (r_mode)
                M_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + CW'(1);
                    if (r_clr_cnt == CW'(CLR_N - 1)) begin
                        r_mode <= M_RUN;
                    end
                end
                M_RUN: begin
                end
                default: begin
                    r_mode <= M_CLEAR;
                end
            endcase
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
                r_fresh    <= 1'b0;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_pc <= n_pc;
            end else if (i_cfg_we && r_fresh) begin
                r_pc <= i_cfg_wdata;
            end
            r_fi     <= n_fi;
            r_base   <= n_base;
            r_top    <= n_top;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1 <= i_in;
        end
        if (w_adv) begin
            r_out <= ex_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt released without reset");

    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> ($stable(r_fi) && $stable(r_top) && $stable(r_base) && $stable(r_pc)))
        else $error("state changed while halted");

    a_halt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_halted) |-> (ex_res.status == ST_HALT))
        else $error("halted block reported a live status");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> (!o_in_ready && !r_s1_valid))
        else $error("transaction taken during memory clear");

    a_frame_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= r_top)
        else $error("frame base above frame top");

endmodule

// File: tb/sfvm_checker.sv
`timescale 1ns / 1ps

module sfvm_checker
    import sfvm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out,
    output int          o_fails,
    output int          o_pending
);

    localparam int REG_COUNT   = 16;
    localparam int STACK_DEPTH = 16;
    localparam int FRAME_DEPTH = 32;

    logic [63:0] vm_regs [REG_COUNT];
    logic [63:0] vm_stack [STACK_DEPTH];
    int          frame_base [FRAME_DEPTH];
    int          frame_top [FRAME_DEPTH];
    logic [15:0] frame_ret [FRAME_DEPTH];
    int          frame_idx;
    logic [15:0] vm_pc;
    logic        halted;
    logic        fresh;
    t_out_item   expected_results [$];

    function automatic t_out_item execute(input t_in_item it);
        t_out_item   res;
        t_status     st;
        logic [15:0] npc;
        int          shared;
        int          base;
        int          top;
        res = '0;
        st = ST_OK;
        npc = vm_pc + 16'd1;
        shared = 1 + int'(it.callee_args);
        base = frame_base[frame_idx];
        top = frame_top[frame_idx];
        fresh = 1'b0;
        if (halted) begin
            st = ST_HALT;
        end else if (it.kind >= K_TO_STACK && it.kind <= K_EMIT && it.reg_a >= REG_COUNT) begin
            st = ST_BADREG;
        end else if (it.kind == K_MOVE && it.reg_b >= REG_COUNT) begin
            st = ST_BADREG;
        end else begin
            case (it.kind)
                K_PUSH: begin
                    if (top + 1 < STACK_DEPTH) frame_top[frame_idx] = top + 1;
                    else st = ST_SOVF;
                end
                K_POP: begin
                    if (base < top) frame_top[frame_idx] = top - 1;
                    else st = ST_SUNF;
                end
                K_TO_STACK: begin
                    if (base < top && top <= STACK_DEPTH) vm_stack[top - 1] = vm_regs[it.reg_a];
                    else st = ST_SUNF;
                end
                K_FROM_STACK: begin
                    if (base < top && top <= STACK_DEPTH) vm_regs[it.reg_a] = vm_stack[top - 1];
                    else st = ST_SUNF;
                end
                K_TO_RETSLOT: begin
                    if (base < STACK_DEPTH) vm_stack[base] = vm_regs[it.reg_a];
                    else st = ST_SOVF;
                end
                K_MOVE: vm_regs[it.reg_b] = vm_regs[it.reg_a];
                K_LOAD: vm_regs[it.reg_a] = it.in_value;
                K_EMIT: begin
                    res.out_valid = 1'b1;
                    res.out_value = vm_regs[it.reg_a];
                end
                K_RETURN: begin
                    if (frame_idx == 0) begin
                        st = ST_HALT;
                    end else if (base + 1 >= STACK_DEPTH) begin
                        st = ST_SOVF;
                    end else begin
                        frame_top[frame_idx] = base + 1;
                        frame_idx--;
                        npc = frame_ret[frame_idx];
                    end
                end
                K_EXIT: begin
                    if (frame_idx == 0 && top == 1) begin
                        st = ST_EXIT;
                        res.exit_value = vm_stack[0];
                    end else begin
                        st = ST_HALT;
                    end
                end
                K_CALL: begin
                    if (frame_idx + 1 >= FRAME_DEPTH) begin
                        st = ST_FOVF;
                    end else if (top < shared || top - shared < base) begin
                        st = ST_SUNF;
                    end else begin
                        frame_ret[frame_idx] = npc;
                        frame_top[frame_idx + 1] = top;
                        frame_base[frame_idx + 1] = top - shared;
                        frame_ret[frame_idx + 1] = 16'd0;
                        frame_idx++;
                        npc = it.callee_entry;
                    end
                end
                default: ;
            endcase
        end
        if (st != ST_OK) begin
            halted = 1'b1;
            npc = vm_pc;
        end
        vm_pc = npc;
        res.next_pc = vm_pc;
        res.status = st;
        return res;
    endfunction

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            o_fails++;
            if (o_fails <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) vm_regs[i] = '0;
            for (int i = 0; i < STACK_DEPTH; i++) vm_stack[i] = '0;
            for (int i = 0; i < FRAME_DEPTH; i++) begin
                frame_base[i] = 0;
                frame_top[i] = 0;
                frame_ret[i] = '0;
            end
            frame_idx = 0;
            vm_pc = '0;
            halted = 1'b0;
            fresh = 1'b1;
            expected_results.delete();
            o_pending = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_fails++;
                    if (o_fails <= 10)
                        $display("%0t: result transaction with nothing pending", $time);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("next_pc", want.next_pc, i_out.next_pc);
                    compare_field("out_valid", want.out_valid, i_out.out_valid);
                    compare_field("out_value", want.out_value, i_out.out_value);
                    compare_field("status", want.status, i_out.status);
                    compare_field("exit_value", want.exit_value, i_out.exit_value);
                end
            end
            if (i_cfg_we) begin
                if (fresh) vm_pc = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(execute(i_in));
            o_pending = expected_results.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sfvm_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int FRAME_DEPTH = 32;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    int check_fails;
    int check_pending;
    int sent_count = 0;
    int recv_count = 0;
    bit in_burst = 1'b0;
    bit out_burst = 1'b0;
    int hold_off = 0;

    // frame layout as the generator expects it, used to keep programs legal
    int gen_frame = 0;
    int gen_base [FRAME_DEPTH];
    int gen_top [FRAME_DEPTH];

    always #5 i_clk = ~i_clk;

    stack_frame_vm_execute_unit_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    sfvm_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .o_fails     (check_fails),
        .o_pending   (check_pending)
    );

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_item make_op(input logic [3:0] kind, input logic [7:0] ra,
                                         input logic [7:0] rb, input logic [63:0] val,
                                         input logic [15:0] entry, input logic [3:0] nargs);
        t_in_item it;
        it.kind = kind;
        it.reg_a = ra;
        it.reg_b = rb;
        it.in_value = val;
        it.callee_entry = entry;
        it.callee_args = nargs;
        return it;
    endfunction

    // legal register operands, random everything the kind ignores
    function automatic t_in_item rand_op(input logic [3:0] kind);
        t_in_item it;
        it.kind = kind;
        it.reg_a = (kind >= K_TO_STACK && kind <= K_EMIT) ? 8'($urandom_range(0, 15))
                                                          : 8'($urandom_range(0, 255));
        it.reg_b = (kind == K_MOVE) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        it.in_value = pick_word();
        it.callee_entry = 16'($urandom_range(0, 65535));
        it.callee_args = (kind == K_CALL) ? 4'd0 : 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic t_in_item pick_instr();
        t_in_item   it;
        logic [3:0] kind;
        int         r;
        int         room;
        r = $urandom_range(0, 99);
        room = gen_top[gen_frame] - gen_base[gen_frame];
        if (r < 16) kind = K_PUSH;
        else if (r < 30) kind = K_POP;
        else if (r < 38) kind = K_TO_STACK;
        else if (r < 46) kind = K_FROM_STACK;
        else if (r < 52) kind = K_TO_RETSLOT;
        else if (r < 60) kind = K_MOVE;
        else if (r < 70) kind = K_LOAD;
        else if (r < 78) kind = K_EMIT;
        else if (r < 86) kind = K_CALL;
        else if (r < 94) kind = K_RETURN;
        else kind = 4'($urandom_range(11, 15));
        if (room == 0 && (kind == K_POP || kind == K_TO_STACK || kind == K_FROM_STACK ||
                          kind == K_CALL))
            kind = K_PUSH;
        if (kind == K_CALL && gen_frame == FRAME_DEPTH - 1) kind = K_RETURN;
        if (kind == K_PUSH && gen_top[gen_frame] >= STACK_DEPTH - 1) kind = K_POP;
        if (kind == K_RETURN && gen_frame == 0) kind = K_EMIT;
        it = rand_op(kind);
        if (kind == K_CALL) it.callee_args = 4'($urandom_range(0, room - 1));
        return it;
    endfunction

    function automatic void track(input t_in_item it);
        case (it.kind)
            K_PUSH: gen_top[gen_frame]++;
            K_POP: gen_top[gen_frame]--;
            K_RETURN: if (gen_frame > 0) gen_frame--;
            K_CALL: begin
                gen_top[gen_frame + 1] = gen_top[gen_frame];
                gen_base[gen_frame + 1] = gen_top[gen_frame] - 1 - int'(it.callee_args);
                gen_frame++;
            end
            default: ;
        endcase
    endfunction

    task automatic send_instr(input t_in_item it);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    task automatic issue(input t_in_item it);
        track(it);
        send_instr(it);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (recv_count == sent_count);
    endtask

    task automatic load_start_address(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // drive the machine into one randomly chosen fault or a clean exit, then poke it halted
    task automatic end_with_fault();
        t_in_item it;
        int       fault;
        fault = $urandom_range(0, 8);
        case (fault)
            0: begin
                while (gen_top[gen_frame] < STACK_DEPTH - 1) issue(rand_op(K_PUSH));
                send_instr(rand_op(K_PUSH));
            end
            1, 2: begin
                while (gen_top[gen_frame] > gen_base[gen_frame]) issue(rand_op(K_POP));
                if (fault == 1) it = rand_op(K_POP);
                else it = rand_op($urandom_range(0, 1) ? K_TO_STACK : K_FROM_STACK);
                send_instr(it);
            end
            3: begin
                it = rand_op(4'($urandom_range(K_TO_STACK, K_EMIT)));
                if (it.kind == K_MOVE && $urandom_range(0, 1)) it.reg_b = 8'($urandom_range(16, 255));
                else it.reg_a = 8'($urandom_range(16, 255));
                send_instr(it);
            end
            4: begin
                while (gen_frame < FRAME_DEPTH - 1) begin
                    if (gen_top[gen_frame] == gen_base[gen_frame]) issue(rand_op(K_PUSH));
                    issue(rand_op(K_CALL));
                end
                send_instr(rand_op(K_CALL));
            end
            5: begin
                if (gen_frame == FRAME_DEPTH - 1) issue(rand_op(K_RETURN));
                it = rand_op(K_CALL);
                it.callee_args = 4'(gen_top[gen_frame] - gen_base[gen_frame]);
                send_instr(it);
            end
            6: begin
                while (gen_frame > 0) issue(rand_op(K_RETURN));
                send_instr(rand_op(K_RETURN));
            end
            7: begin
                while (gen_frame > 0) issue(rand_op(K_RETURN));
                while (gen_top[0] > 1) issue(rand_op(K_POP));
                if (gen_top[0] == 0) issue(rand_op(K_PUSH));
                it = rand_op(K_LOAD);
                issue(it);
                it.kind = K_TO_STACK;
                issue(it);
                send_instr(rand_op(K_EXIT));
            end
            default: begin
                if (gen_frame == 0 && gen_top[0] == 1) issue(rand_op(K_PUSH));
                send_instr(rand_op(K_EXIT));
            end
        endcase
        repeat (10) send_instr(rand_op(4'($urandom_range(0, 15))));
    endtask

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, 19);
            if (hold_off > 0) begin
                stall = hold_off;
                hold_off = 0;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            recv_count++;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        for (int i = 0; i < FRAME_DEPTH; i++) begin
            gen_base[i] = 0;
            gen_top[i] = 0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_start_address(16'h0000);
        load_start_address(16'hFFFF);
        if ($urandom_range(0, 1)) load_start_address(16'($urandom_range(0, 65535)));

        issue(make_op(K_LOAD, 8'd0, 8'd0, '1, 16'd0, 4'd0));
        issue(make_op(K_LOAD, 8'd15, 8'hFF, 64'd0, 16'hFFFF, 4'd15));
        issue(make_op(K_EMIT, 8'd0, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_EMIT, 8'd15, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_MOVE, 8'd0, 8'd15, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_PUSH, 8'hFF, 8'hFF, '1, 16'hFFFF, 4'd15));
        issue(make_op(K_TO_STACK, 8'd15, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_PUSH, 8'd0, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_LOAD, 8'd1, 8'd0, 64'h8000_0000_0000_0001, 16'd0, 4'd0));
        issue(make_op(K_TO_STACK, 8'd1, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_FROM_STACK, 8'd2, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_EMIT, 8'd2, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_CALL, 8'd0, 8'd0, 64'd0, 16'hFFFF, 4'd1));
        issue(make_op(K_TO_RETSLOT, 8'd1, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_CALL, 8'hFF, 8'hFF, 64'd0, 16'h0000, 4'd1));
        issue(make_op(K_POP, 8'd0, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(4'd15, 8'hFF, 8'hFF, '1, 16'hFFFF, 4'd15));
        issue(make_op(K_RETURN, 8'd0, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_RETURN, 8'd0, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(4'd11, 8'd0, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_POP, 8'd0, 8'd0, 64'd0, 16'd0, 4'd0));
        issue(make_op(K_EMIT, 8'd15, 8'd0, 64'd0, 16'd0, 4'd0));

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: load_start_address(16'hFFFF);
                1: load_start_address(16'h0000);
                default: load_start_address(16'($urandom_range(0, 65535)));
            endcase
            in_burst = (phase == 2);
            out_burst = (phase == 3);
            // long receiver hold-off so the pipeline backs up into the input
            if (phase == 1) hold_off = 300;
            repeat (450) issue(pick_instr());
        end
        in_burst = 1'b0;
        out_burst = 1'b0;
        end_with_fault();
        settle();
        repeat (20) @(posedge i_clk);

        if (check_fails == 0 && check_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
